### rtl/shelf_rect_packer_top_macros.svh
// Assertion macros for the shelf packer checker.
// Clocked on clock, disabled while reset is high; used by shrp_checker only.
`ifndef SHELF_RECT_PACKER_TOP_MACROS_SVH
`define SHELF_RECT_PACKER_TOP_MACROS_SVH

// same-cycle implication
`define SHRP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("shelf packer check failed");

// next-cycle implication
`define SHRP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shelf packer check failed");

`endif

### rtl/shrp_pkg.sv
// Shared types and constants for the shelf rectangle packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package shrp_pkg;

   localparam int GLYPH_W = 13;
   localparam int COORD_W = 14;
   localparam int PROD_W  = 2 * GLYPH_W;
   localparam int CNT_W   = $clog2(PROD_W + 1);

   localparam logic [COORD_W-1:0] COORD_MAX   = {COORD_W{1'b1}};
   localparam logic [COORD_W-1:0] ATLAS_RESET = COORD_W'(1024);

   // last multiplier step, last divider step (step zero of the divider loads it)
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(GLYPH_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W);

   typedef logic [0:0] csr_addr_type;
   localparam csr_addr_type CSR_ATLAS_WIDTH  = 1'b0;
   localparam csr_addr_type CSR_ATLAS_HEIGHT = 1'b1;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph_width;
      logic [GLYPH_W-1:0] glyph_height;
      logic [GLYPH_W-1:0] font_height;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] rect_x;
      logic [COORD_W-1:0] rect_y;
      logic [COORD_W-1:0] rect_width;
      logic               placed;
   } rsp_type;

   typedef struct packed {
      logic wrap_step;
      logic commit_step;
   } place_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_WRAP,
      ST_COMMIT
   } state_type;

endpackage

### rtl/shelf_rect_packer_top.sv
// Channel   Direction  Payload           Handshake
// req_      in         shrp_pkg::req_type  req_valid / req_stall
// rsp_      out        shrp_pkg::rsp_type  rsp_valid / rsp_stall
// csr_      in         14-bit register   csr_we / csr_addr, no read-back
//
// Each glyph runs through the serial multiplier (one bit of font_height a cycle),
// the radix-2 divider (load plus 26 quotient bits), one shelf wrap and one commit;
// the next glyph is only accepted once the last one has committed.
// req_stall is high from acceptance until the result enters the output register.
// A stalled result holds in the output register; a finished glyph waits to commit.
// Reset is synchronous and restores the atlas to 1024 by 1024 with empty shelves.
`timescale 1ns / 1ps
module shelf_rect_packer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  shrp_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output shrp_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  shrp_pkg::csr_addr_type        csr_addr,
   input  logic [shrp_pkg::COORD_W-1:0]  csr_wdata
);
   import shrp_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   req_type            req_ff, req_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [COORD_W-1:0] atlas_w_ff, atlas_w_in;
   logic [COORD_W-1:0] atlas_h_ff, atlas_h_in;

   logic               mul_start, mul_step;
   logic               div_load, div_step;
   place_ctl_type      ctl;
   logic [PROD_W-1:0]  product;
   logic [PROD_W-1:0]  quotient;
   logic [COORD_W-1:0] width;
   rsp_type            result;

   assign width = (|quotient[PROD_W-1:COORD_W]) ? COORD_MAX : quotient[COORD_W-1:0];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      mul_start    = 1'b0;
      mul_step     = 1'b0;
      div_load     = 1'b0;
      div_step     = 1'b0;
      ctl          = '0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      atlas_w_in   = atlas_w_ff;
      atlas_h_in   = atlas_h_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_ATLAS_WIDTH:  atlas_w_in = csr_wdata;
            CSR_ATLAS_HEIGHT: atlas_h_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               mul_start = 1'b1;
               cnt_in    = '0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            mul_step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // step zero loads the product
            div_load = (cnt_ff == '0);
            div_step = (cnt_ff != '0);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            ctl.wrap_step = 1'b1;
            state_in      = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.commit_step = 1'b1;
               rsp_in          = result;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         atlas_w_ff   <= ATLAS_RESET;
         atlas_h_ff   <= ATLAS_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         atlas_w_ff   <= atlas_w_in;
         atlas_h_ff   <= atlas_h_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   shrp_mul u_mul (
      .clock        (clock),
      .start        (mul_start),
      .step         (mul_step),
      .multiplicand (req_ff.glyph_width),
      .multiplier   (req_data.font_height),
      .product      (product)
   );

   shrp_div u_div (
      .clock    (clock),
      .load     (div_load),
      .step     (div_step),
      .dividend (product),
      .divisor  (req_ff.glyph_height),
      .quotient (quotient)
   );

   shrp_place u_place (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .atlas_width  (atlas_w_ff),
      .atlas_height (atlas_h_ff),
      .width        (width),
      .font_height  (req_ff.font_height),
      .result       (result)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/shrp_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle while step is high, LSB first.
// Depends on shrp_pkg.
`timescale 1ns / 1ps
module shrp_mul (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic [shrp_pkg::GLYPH_W-1:0]  multiplicand,
   input  logic [shrp_pkg::GLYPH_W-1:0]  multiplier,
   output logic [shrp_pkg::PROD_W-1:0]   product
);
   import shrp_pkg::*;

   logic [PROD_W-1:0]  acc_ff;
   logic [PROD_W-1:0]  acc_in;
   logic [GLYPH_W:0]   sum;

   // upper half accumulates, lower half holds the multiplier bits still to go
   always_comb begin
      sum    = {1'b0, acc_ff[PROD_W-1:GLYPH_W]}
             + (acc_ff[0] ? {1'b0, multiplicand} : {(GLYPH_W+1){1'b0}});
      acc_in = acc_ff;
      if (start) begin
         acc_in = {{GLYPH_W{1'b0}}, multiplier};
      end else if (step) begin
         acc_in = {sum, acc_ff[GLYPH_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign product = acc_ff;

endmodule

### rtl/shrp_div.sv
// Restoring radix-2 divider: one quotient bit per cycle while step is high, MSB first.
// Depends on shrp_pkg. A zero divisor yields an all-ones quotient.
`timescale 1ns / 1ps
module shrp_div (
   input  logic                          clock,
   input  logic                          load,
   input  logic                          step,
   input  logic [shrp_pkg::PROD_W-1:0]   dividend,
   input  logic [shrp_pkg::GLYPH_W-1:0]  divisor,
   output logic [shrp_pkg::PROD_W-1:0]   quotient
);
   import shrp_pkg::*;

   logic [GLYPH_W-1:0] rem_ff;
   logic [GLYPH_W-1:0] rem_in;
   logic [PROD_W-1:0]  dvd_ff;
   logic [PROD_W-1:0]  dvd_in;
   logic [GLYPH_W+1:0] trial;
   logic               qbit;

   // dividend bits shift out the top while quotient bits shift in below
   always_comb begin
      trial  = {1'b0, rem_ff, dvd_ff[PROD_W-1]} - {2'b00, divisor};
      qbit   = ~trial[GLYPH_W+1];
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      if (load) begin
         rem_in = '0;
         dvd_in = dividend;
      end else if (step) begin
         rem_in = qbit ? trial[GLYPH_W-1:0] : {rem_ff[GLYPH_W-2:0], dvd_ff[PROD_W-1]};
         dvd_in = {dvd_ff[PROD_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign quotient = dvd_ff;

endmodule

### rtl/shrp_place.sv
// Shelf state and placement decision: a wrap step, then a commit step.
// Depends on shrp_pkg.
`timescale 1ns / 1ps
module shrp_place (
   input  logic                          clock,
   input  logic                          reset,
   input  shrp_pkg::place_ctl_type       ctl,
   input  logic [shrp_pkg::COORD_W-1:0]  atlas_width,
   input  logic [shrp_pkg::COORD_W-1:0]  atlas_height,
   input  logic [shrp_pkg::COORD_W-1:0]  width,
   input  logic [shrp_pkg::GLYPH_W-1:0]  font_height,
   output shrp_pkg::rsp_type             result
);
   import shrp_pkg::*;

   logic [COORD_W-1:0] cursor_ff, cursor_in;
   logic [COORD_W-1:0] top_ff, top_in;
   logic [GLYPH_W-1:0] shelf_h_ff, shelf_h_in;
   logic [COORD_W-1:0] rx_ff, rx_in;
   logic [COORD_W-1:0] ry_pre_ff, ry_pre_in;

   logic               wrap;
   logic               ok;
   logic [COORD_W:0]   top_sum;
   logic [COORD_W:0]   cursor_sum;
   logic [COORD_W:0]   bottom;
   logic [GLYPH_W-1:0] shelf_h_base;

   always_comb begin
      cursor_sum   = {1'b0, cursor_ff} + {1'b0, width};
      wrap         = cursor_sum >= {1'b0, atlas_width};
      top_sum      = {1'b0, top_ff} + {2'b00, shelf_h_ff};
      bottom       = {1'b0, top_ff} + {2'b00, font_height};
      ok           = bottom < {1'b0, atlas_height};
      shelf_h_base = wrap ? '0 : shelf_h_ff;

      cursor_in  = cursor_ff;
      top_in     = top_ff;
      shelf_h_in = shelf_h_ff;
      rx_in      = rx_ff;
      ry_pre_in  = ry_pre_ff;

      if (ctl.wrap_step) begin
         rx_in      = wrap ? '0 : cursor_ff;
         ry_pre_in  = top_ff;
         shelf_h_in = (font_height > shelf_h_base) ? font_height : shelf_h_base;
         if (wrap) begin
            cursor_in = '0;
            top_in    = top_sum[COORD_W] ? COORD_MAX : top_sum[COORD_W-1:0];
         end
      end else if (ctl.commit_step && ok) begin
         // advance only for a glyph that fits above the bottom edge
         cursor_in = cursor_sum[COORD_W] ? COORD_MAX : cursor_sum[COORD_W-1:0];
      end

      result.rect_x     = rx_ff;
      result.rect_y     = ok ? top_ff : ry_pre_ff;
      result.rect_width = width;
      result.placed     = ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff  <= '0;
         top_ff     <= '0;
         shelf_h_ff <= '0;
      end else begin
         cursor_ff  <= cursor_in;
         top_ff     <= top_in;
         shelf_h_ff <= shelf_h_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff     <= rx_in;
      ry_pre_ff <= ry_pre_in;
   end

endmodule

### rtl/shrp_checker.sv
// Port-level checks for shelf_rect_packer_top, attached by bind below.
// Depends on shrp_pkg and shelf_rect_packer_top_macros.svh.
`timescale 1ns / 1ps
`include "shelf_rect_packer_top_macros.svh"
module shrp_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  shrp_pkg::rsp_type rsp_data
);
   import shrp_pkg::*;

   // a stalled beat holds
   `SHRP_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   // one glyph at a time: busy right after acceptance
   `SHRP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // no result can be produced the cycle after acceptance
   `SHRP_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall, !rsp_valid || $stable(rsp_data))
   // a fresh result only comes out of a busy block
   `SHRP_ASSERT_NOW(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))

endmodule

bind shelf_rect_packer_top shrp_checker u_shrp_checker (.*);
